// ===== rtl/acs_pkg.sv =====
// acs_pkg: shared constants, codes and keyword table of the AT command sequencer.
// No dependencies; imported by at_command_sequencer, acs_assert, acs_check and at_command_sequencer_tb.

package acs_pkg;

  // Command queue geometry
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam logic CFG_TIMEOUT   = 1'b0;
  localparam logic CFG_RESET_CMD = 1'b1;

  // Reset values of the configuration registers
  localparam logic [3:0] TIMEOUT_RST   = 4'd5;
  localparam logic [7:0] RESET_CMD_RST = 8'd0;

  // Item operations
  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_RX_BYTE = 2'd1,
    OP_SERVICE = 2'd2
  } op_e;

  // Link states
  localparam logic [1:0] ST_READY   = 2'd0;
  localparam logic [1:0] ST_WAIT    = 2'd1;
  localparam logic [1:0] ST_GOT     = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  // Return codes (keyword index, plus unknown)
  localparam logic [2:0] RC_READY   = 3'd0;
  localparam logic [2:0] RC_OK      = 3'd1;
  localparam logic [2:0] RC_SEND_OK = 3'd2;
  localparam logic [2:0] RC_BUSY    = 3'd3;
  localparam logic [2:0] RC_FAIL    = 3'd4;
  localparam logic [2:0] RC_ERROR   = 3'd5;
  localparam logic [2:0] RC_UNKNOWN = 3'd6;

  // Response keywords
  localparam int unsigned KEY_NUM = 6;
  localparam int unsigned KEY_MAX = 12;
  localparam int unsigned KEY_K_W = $clog2(KEY_NUM);
  localparam logic [7:0]  LF      = 8'h0A;
  localparam logic [3:0]  POS_MAX = 4'd15;

  localparam logic [3:0] KEY_LEN [KEY_NUM] = '{4'd7, 4'd4, 4'd9, 4'd11, 4'd6, 4'd7};

  localparam logic [7:0] KEY_TEXT [KEY_NUM][KEY_MAX] = '{
    // "ready\r\n"
    '{8'h72, 8'h65, 8'h61, 8'h64, 8'h79, 8'h0D, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    // "OK\r\n"
    '{8'h4F, 8'h4B, 8'h0D, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    // "SEND OK\r\n"
    '{8'h53, 8'h45, 8'h4E, 8'h44, 8'h20, 8'h4F, 8'h4B, 8'h0D, 8'h0A, 8'h00, 8'h00, 8'h00},
    // "busy p...\r\n"
    '{8'h62, 8'h75, 8'h73, 8'h79, 8'h20, 8'h70, 8'h2E, 8'h2E, 8'h2E, 8'h0D, 8'h0A, 8'h00},
    // "FAIL\r\n"
    '{8'h46, 8'h41, 8'h49, 8'h4C, 8'h0D, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    // "ERROR\r\n"
    '{8'h45, 8'h52, 8'h52, 8'h4F, 8'h52, 8'h0D, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  // True when keyword k still agrees with byte b at line position pos
  function automatic logic key_char_ok(logic [KEY_K_W-1:0] k, logic [3:0] pos,
                                       logic [7:0] b);
    logic ok;
    ok = 1'b0;
    if (pos < KEY_LEN[k] && pos < 4'(KEY_MAX)) begin
      ok = (KEY_TEXT[k][pos] == b);
    end
    return ok;
  endfunction

endpackage

// ===== rtl/at_command_sequencer.sv =====
// at_command_sequencer: AT command queue, response line matcher and link state machine.
// Depends on acs_pkg for codes, queue geometry and the keyword table.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | input     | in_valid_i/in_ready_o | operation, command_id, rx_byte, new_second
//  out     | output    | out_valid_o/out_ready_i | enqueue_accepted, send_*, line_matched,
//          |           |                       | return_code, link_state
//  cfg     | input     | cfg_we_i              | cfg_index_i, cfg_wdata_i
//
// One item per cycle while results are taken: an item is processed in the cycle of its transfer
// and its result sits in the output register from the next cycle on.
// A new item is taken while the output register is empty or being drained, so a stalled
// consumer holds the input side off only while a result is pending.
// Reset clears the link state, queue pointers and matcher; the queue entries are not cleared.

module at_command_sequencer
  import acs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_wdata_i,
  // input items
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] command_id_i,
  input  logic [7:0] rx_byte_i,
  input  logic       new_second_i,
  // result items
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       enqueue_accepted_o,
  output logic       send_valid_o,
  output logic [7:0] send_command_id_o,
  output logic       line_matched_o,
  output logic [2:0] return_code_o,
  output logic [1:0] link_state_o
);

  // Configuration registers
  logic [3:0] timeout_q;
  logic [7:0] reset_cmd_q;

  // Control state
  logic [1:0]        state_q, state_d;
  logic [2:0]        code_q, code_d;
  logic [3:0]        elapsed_q, elapsed_d;
  logic [QPTR_W-1:0] head_q, head_d;
  logic [QPTR_W-1:0] tail_q, tail_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic [3:0]        pos_q, pos_d;
  logic [KEY_NUM-1:0] mask_q, mask_d;

  // Queue storage
  logic [7:0] store_q [QUEUE_DEPTH];

  // Result register
  logic       out_valid_q;
  logic       acc_q, acc_d;
  logic       send_q, send_d;
  logic [7:0] send_id_q, send_id_d;
  logic       match_q, match_d;

  // Item processing
  logic       take;
  logic       put_req;
  logic [7:0] put_id;
  logic       put_ok;
  logic [QCNT_W-1:0] count_put;
  logic       get_ok;
  logic [KEY_NUM-1:0] cand;
  logic [3:0] el_inc;
  logic       svc_stop;
  logic [1:0] st_svc;

  assign take       = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= TIMEOUT_RST;
      reset_cmd_q <= RESET_CMD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TIMEOUT:   timeout_q   <= cfg_wdata_i[3:0];
        CFG_RESET_CMD: reset_cmd_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Next state and result of one item
  always_comb begin
    state_d   = state_q;
    code_d    = code_q;
    elapsed_d = elapsed_q;
    pos_d     = pos_q;
    mask_d    = mask_q;
    put_req   = 1'b0;
    put_id    = command_id_i;
    get_ok    = 1'b0;
    acc_d     = 1'b0;
    send_d    = 1'b0;
    send_id_d = '0;
    match_d   = 1'b0;
    svc_stop  = 1'b0;
    st_svc    = state_q;
    el_inc    = elapsed_q + 4'd1;
    cand      = '0;

    for (int k = 0; k < KEY_NUM; k++) begin
      cand[k] = mask_q[k] && key_char_ok(KEY_K_W'(k), pos_q, rx_byte_i);
    end

    unique case (operation_i)
      OP_ENQUEUE: begin
        put_req = 1'b1;
      end
      OP_RX_BYTE: begin
        mask_d = cand;
        if (rx_byte_i == LF) begin
          // first keyword whose full length ends on this byte wins
          for (int k = KEY_NUM - 1; k >= 0; k--) begin
            if (cand[k] && KEY_LEN[k] == pos_q + 4'd1) begin
              match_d = 1'b1;
              code_d  = 3'(k);
            end
          end
          if (match_d) begin
            state_d = ST_GOT;
          end
          pos_d  = '0;
          mask_d = '1;
        end else if (pos_q < POS_MAX) begin
          pos_d = pos_q + 4'd1;
        end
      end
      OP_SERVICE: begin
        put_id = reset_cmd_q;
        // second tick: timeout recovery and response aging
        if (new_second_i) begin
          if (state_q == ST_TIMEOUT) begin
            put_req = 1'b1;
            st_svc  = ST_READY;
          end else if (state_q == ST_WAIT) begin
            if (el_inc >= timeout_q) begin
              elapsed_d = '0;
              st_svc    = ST_TIMEOUT;
            end else begin
              elapsed_d = el_inc;
            end
          end
        end
        // response handling
        if (st_svc == ST_GOT) begin
          if (code_q == RC_BUSY || code_q == RC_UNKNOWN) begin
            svc_stop = 1'b1;
          end else if (code_q == RC_ERROR || code_q == RC_FAIL) begin
            code_d   = RC_UNKNOWN;
            st_svc   = ST_READY;
            put_req  = 1'b1;
            svc_stop = 1'b1;
          end else begin
            code_d = RC_UNKNOWN;
            st_svc = ST_READY;
          end
        end
        // dispatch from ready; a put into an empty queue always succeeds
        if (!svc_stop && st_svc == ST_READY && (count_q != '0 || put_req)) begin
          get_ok = 1'b1;
          st_svc = ST_WAIT;
        end
        state_d = st_svc;
      end
      default: ;
    endcase

    put_ok    = put_req && (count_q < QCNT_W'(QUEUE_DEPTH));
    count_put = put_ok ? count_q + QCNT_W'(1) : count_q;
    if (operation_i == OP_ENQUEUE) begin
      acc_d = put_ok;
    end

    if (get_ok) begin
      send_d = 1'b1;
      // an empty queue hands over the entry just written
      send_id_d = (count_q == '0) ? put_id : store_q[head_q];
    end

    tail_d  = tail_q;
    head_d  = head_q;
    count_d = get_ok ? count_put - QCNT_W'(1) : count_put;
    if (put_ok) begin
      tail_d = (tail_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + QPTR_W'(1);
    end
    if (get_ok) begin
      head_d = (head_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + QPTR_W'(1);
    end
  end

  // Control state update on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_READY;
      code_q    <= RC_READY;
      elapsed_q <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      pos_q     <= '0;
      mask_q    <= '1;
    end else if (take) begin
      state_q   <= state_d;
      code_q    <= code_d;
      elapsed_q <= elapsed_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      pos_q     <= pos_d;
      mask_q    <= mask_d;
    end
  end

  // Queue entry write
  always_ff @(posedge clk_i) begin
    if (take && put_ok) begin
      store_q[tail_q] <= put_id;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      acc_q     <= acc_d;
      send_q    <= send_d;
      send_id_q <= send_id_d;
      match_q   <= match_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign enqueue_accepted_o = acc_q;
  assign send_valid_o       = send_q;
  assign send_command_id_o  = send_id_q;
  assign line_matched_o     = match_q;
  assign return_code_o      = code_q;
  assign link_state_o       = state_q;

endmodule

// ===== rtl/acs_check.sv =====
// acs_assert: port-level checks of at_command_sequencer, bound to the top level.
// Depends on acs_pkg for link state and return codes.

module acs_assert
  import acs_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       enqueue_accepted_o,
  input logic       send_valid_o,
  input logic [7:0] send_command_id_o,
  input logic       line_matched_o,
  input logic [2:0] return_code_o,
  input logic [1:0] link_state_o
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(send_command_id_o)
      && $stable(link_state_o) && $stable(return_code_o))
    else $error("result changed while stalled");

  // A dispatch always leaves the link waiting for a response
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && send_valid_o |-> link_state_o == ST_WAIT)
    else $error("dispatch without wait state");

  // A matched line reports got-response with a keyword code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_matched_o |-> link_state_o == ST_GOT
      && return_code_o != RC_UNKNOWN)
    else $error("matched line without got-response");

  // No dispatch means a zero identifier, and one item never both enqueues and sends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (send_valid_o || send_command_id_o == 8'd0)
      && !(send_valid_o && enqueue_accepted_o))
    else $error("inconsistent result flags");

  // The input side is open whenever no result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output register");

endmodule

bind at_command_sequencer acs_assert u_acs_assert (.*);

// ===== tb/acs_check.sv =====
// acs_check: result checker for the AT command sequencer; watches config, input and output.
// Depends on acs_pkg for codes, queue geometry and the keyword table.

module acs_check
  import acs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  command_id_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        new_second_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        enqueue_accepted_i,
  input  logic        send_valid_i,
  input  logic [7:0]  send_command_id_i,
  input  logic        line_matched_i,
  input  logic [2:0]  return_code_i,
  input  logic [1:0]  link_state_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic       accepted;
    logic       sent;
    logic [7:0] sent_id;
    logic       matched;
    logic [2:0] code;
    logic [1:0] link;
  } link_result_t;

  // Shadow of the sequencer state
  logic [3:0]        cfg_timeout;
  logic [7:0]        cfg_reset_cmd;
  logic [1:0]        link_q;
  logic [2:0]        rc_q;
  logic [3:0]        secs_q;
  logic [7:0]        cmd_fifo [QUEUE_DEPTH];
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QCNT_W-1:0] fill;
  logic [3:0]        line_pos;
  logic [KEY_NUM-1:0] live_keys;

  link_result_t awaited_results [$];
  int unsigned  error_cnt;
  int unsigned  due_cnt;

  assign errors_o  = error_cnt;
  assign pending_o = due_cnt;

  // Push into the command FIFO; refused when full
  function automatic logic fifo_push(logic [7:0] id);
    if (fill >= QCNT_W'(QUEUE_DEPTH)) return 1'b0;
    cmd_fifo[wr_ptr] = id;
    wr_ptr = wr_ptr + 1'b1;
    fill   = fill + 1'b1;
    return 1'b1;
  endfunction

  // Next-state and result of one transfer
  task automatic predict_link(input logic [1:0] op, input logic [7:0] cid,
                              input logic [7:0] b, input logic tick,
                              output link_result_t r);
    int   k;
    logic keep;
    logic allow;
    r = '0;
    case (op)
      OP_ENQUEUE: r.accepted = fifo_push(cid);
      OP_RX_BYTE: begin
        // drop keywords that disagree at this position
        for (k = 0; k < KEY_NUM; k++) begin
          if (live_keys[k]) begin
            keep = 1'b0;
            if (line_pos < KEY_LEN[k]) keep = (KEY_TEXT[k][line_pos] == b);
            if (!keep) live_keys[k] = 1'b0;
          end
        end
        if (b == LF) begin
          for (k = 0; k < KEY_NUM; k++) begin
            if (!r.matched && live_keys[k] && int'(KEY_LEN[k]) == int'(line_pos) + 1) begin
              r.matched = 1'b1;
              link_q    = ST_GOT;
              rc_q      = 3'(k);
            end
          end
          line_pos  = '0;
          live_keys = '1;
        end else if (line_pos < POS_MAX) begin
          line_pos = line_pos + 1'b1;
        end
      end
      OP_SERVICE: begin
        allow = 1'b1;
        // second tick: timeout recovery and aging
        if (tick) begin
          if (link_q == ST_TIMEOUT) begin
            void'(fifo_push(cfg_reset_cmd));
            link_q = ST_READY;
          end else if (link_q == ST_WAIT) begin
            secs_q = secs_q + 1'b1;
            if (secs_q >= cfg_timeout) begin
              secs_q = '0;
              link_q = ST_TIMEOUT;
            end
          end
        end
        // handle a received response
        if (link_q == ST_GOT) begin
          if (rc_q == RC_BUSY || rc_q == RC_UNKNOWN) begin
            allow = 1'b0;
          end else if (rc_q == RC_ERROR || rc_q == RC_FAIL) begin
            rc_q   = RC_UNKNOWN;
            link_q = ST_READY;
            void'(fifo_push(cfg_reset_cmd));
            allow  = 1'b0;
          end else begin
            rc_q   = RC_UNKNOWN;
            link_q = ST_READY;
          end
        end
        // dispatch only from ready
        if (allow && link_q == ST_READY && fill != '0) begin
          r.sent    = 1'b1;
          r.sent_id = cmd_fifo[rd_ptr];
          rd_ptr    = rd_ptr + 1'b1;
          fill      = fill - 1'b1;
          link_q    = ST_WAIT;
        end
      end
      default: ;
    endcase
    r.code = rc_q;
    r.link = link_q;
  endtask

  function automatic void check_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      error_cnt++;
    end
  endfunction

  // Sample at the rising edge; config, then drain side, then accept side
  always @(posedge clk_i or negedge rst_ni) begin
    link_result_t want;
    link_result_t got;
    if (!rst_ni) begin
      cfg_timeout   = TIMEOUT_RST;
      cfg_reset_cmd = RESET_CMD_RST;
      link_q        = ST_READY;
      rc_q          = RC_READY;
      secs_q        = '0;
      rd_ptr        = '0;
      wr_ptr        = '0;
      fill          = '0;
      line_pos      = '0;
      live_keys     = '1;
      awaited_results.delete();
      error_cnt     = 0;
      due_cnt       = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_TIMEOUT) cfg_timeout = cfg_wdata_i[3:0];
        else cfg_reset_cmd = cfg_wdata_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result transfer with nothing expected, actual %0d/%0d/%0d", $time,
                   send_command_id_i, return_code_i, link_state_i);
          error_cnt++;
        end else begin
          want = awaited_results.pop_front();
          check_field("enqueue_accepted", want.accepted, enqueue_accepted_i);
          check_field("send_valid", want.sent, send_valid_i);
          check_field("send_command_id", want.sent_id, send_command_id_i);
          check_field("line_matched", want.matched, line_matched_i);
          check_field("return_code", want.code, return_code_i);
          check_field("link_state", want.link, link_state_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_link(operation_i, command_id_i, rx_byte_i, new_second_i, got);
        awaited_results.push_back(got);
      end
      due_cnt = awaited_results.size();
    end
  end

endmodule

// ===== tb/at_command_sequencer_tb.sv =====
// at_command_sequencer_tb: stimulus, handshake pacing and verdict for at_command_sequencer.
// Depends on acs_pkg, the block under test and the acs_check checker.

module at_command_sequencer_tb;
  import acs_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 300000;
  localparam int         PHASES      = 4;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [7:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  operation_i;
  logic [7:0]  command_id_i;
  logic [7:0]  rx_byte_i;
  logic        new_second_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        enqueue_accepted_o;
  logic        send_valid_o;
  logic [7:0]  send_command_id_o;
  logic        line_matched_o;
  logic [2:0]  return_code_o;
  logic [1:0]  link_state_o;
  int unsigned error_total;
  int unsigned results_due;

  int unsigned items_sent;
  int          burst_left;
  bit          hold_request;

  always #4 clk_i = ~clk_i;

  at_command_sequencer u_top (.*);

  acs_check u_check (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .operation_i, .command_id_i, .rx_byte_i,
    .new_second_i, .out_valid_i(out_valid_o), .out_ready_i,
    .enqueue_accepted_i(enqueue_accepted_o), .send_valid_i(send_valid_o),
    .send_command_id_i(send_command_id_o), .line_matched_i(line_matched_o),
    .return_code_i(return_code_o), .link_state_i(link_state_o),
    .errors_o(error_total), .pending_o(results_due)
  );

  // One input transfer, with random gaps between bursts
  task automatic put_item(input logic [1:0] op, input logic [7:0] cid,
                          input logic [7:0] b, input logic tick);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        @(negedge clk_i) in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    command_id_i <= cid;
    rx_byte_i    <= b;
    new_second_i <= tick;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic push_cmd(input logic [7:0] cid);
    put_item(OP_ENQUEUE, cid, 8'($urandom), 1'($urandom));
  endtask

  task automatic feed(input logic [7:0] b);
    put_item(OP_RX_BYTE, 8'($urandom), b, 1'($urandom));
  endtask

  task automatic step_link(input logic tick);
    put_item(OP_SERVICE, 8'($urandom), 8'($urandom), tick);
  endtask

  task automatic send_line(input int kw);
    for (int i = 0; i < int'(KEY_LEN[kw]); i++) feed(KEY_TEXT[kw][i]);
  endtask

  // Stop offering and wait until every result is back
  task automatic settle();
    @(negedge clk_i) in_valid_i <= 1'b0;
    burst_left = 0;
    while (results_due != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [7:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i) cfg_we_i <= 1'b0;
  endtask

  // Receiver: steady or choppy stretches, plus one long hold on request
  initial begin
    int  run;
    bit  steady;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        @(negedge clk_i) out_ready_i <= 1'b0;
        repeat (80) @(negedge clk_i);
      end else begin
        run    = $urandom_range(8, 40);
        steady = ($urandom_range(0, 3) == 0);
        repeat (run) begin
          @(negedge clk_i);
          out_ready_i <= steady ? 1'b1 : ($urandom_range(0, 9) > 2);
        end
      end
    end
  end

  // Watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    logic [3:0] phase_timeout [PHASES];
    logic [7:0] phase_reset_cmd [PHASES];
    int         pick;
    int         kw;
    int         cut;
    int         target;
    bit         held;
    bit         drained;
    phase_timeout   = '{4'd0, 4'd15, 4'd5, 4'd2};
    phase_reset_cmd = '{8'h00, 8'hFF, 8'h3C, 8'hC3};
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = CFG_TIMEOUT;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    operation_i  = OP_ENQUEUE;
    command_id_i = '0;
    rx_byte_i    = '0;
    new_second_i = 1'b0;
    items_sent   = 0;
    burst_left   = 0;
    hold_request = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: short timeout, all-ones reset command
    write_cfg(CFG_TIMEOUT, {4'hA, 4'd1});
    write_cfg(CFG_RESET_CMD, 8'hFF);
    put_item(OP_UNUSED, 8'hFF, 8'hFF, 1'b1);
    push_cmd(8'h00);
    push_cmd(8'hFF);
    step_link(1'b0);            // dispatch 0x00
    send_line(RC_OK);
    step_link(1'b1);            // OK handled, dispatch 0xFF
    step_link(1'b1);            // times out
    step_link(1'b1);            // reset command queued and sent
    send_line(RC_ERROR);
    step_link(1'b0);            // error queues reset command, no dispatch
    repeat (8) push_cmd(8'($urandom));  // last one refused
    settle();

    // Random phases, one config setting each
    for (int p = 0; p < PHASES; p++) begin
      write_cfg(CFG_TIMEOUT, {4'($urandom), phase_timeout[p]});
      write_cfg(CFG_RESET_CMD, phase_reset_cmd[p]);
      target  = items_sent + 300;
      held    = 1'b0;
      drained = 1'b0;
      while (items_sent < target) begin
        if (!held && items_sent + 200 >= target) begin
          held         = 1'b1;
          hold_request = 1'b1;
        end
        if (!drained && items_sent + 100 >= target) begin
          drained = 1'b1;
          settle();
        end
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
          push_cmd(8'($urandom));
        end else if (pick < 50) begin
          step_link(1'($urandom_range(0, 1)));
        end else if (pick < 75) begin
          send_line($urandom_range(0, KEY_NUM - 1));
        end else if (pick < 85) begin
          // damaged keyword: truncated or one byte replaced
          kw  = $urandom_range(0, KEY_NUM - 1);
          cut = $urandom_range(0, int'(KEY_LEN[kw]) - 2);
          if ($urandom_range(0, 1)) begin
            for (int i = 0; i < cut; i++) feed(KEY_TEXT[kw][i]);
            feed(LF);
          end else begin
            for (int i = 0; i < int'(KEY_LEN[kw]); i++)
              feed(i == cut ? 8'($urandom) : KEY_TEXT[kw][i]);
          end
        end else if (pick < 88) begin
          // line longer than any keyword, position saturates
          repeat ($urandom_range(16, 20)) feed(8'($urandom_range(8'h20, 8'h7E)));
          feed(LF);
        end else if (pick < 95) begin
          feed(8'($urandom));
          if ($urandom_range(0, 1)) feed(LF);
        end else begin
          put_item(OP_UNUSED, 8'($urandom), 8'($urandom), 1'($urandom));
        end
      end
      settle();
    end

    if (error_total == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
